/* src/hbs_pkg.sv */
// shared types and constants of the heightmap bilinear sampler
`timescale 1ns / 1ps
`default_nettype none
package hbs_pkg;

  localparam int VAL_W   = 24;  // stored height, signed Q16.8
  localparam int SIZE_W  = 7;   // grid size register width
  localparam int OFS_W   = 14;  // linear offset inside the grid in use
  localparam int FRAC_W  = 16;  // interpolation weight
  localparam int QDEPTH  = 4;   // entries of the front-to-back queue
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } hbs_op_e;

  typedef enum logic {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } hbs_cfg_e;

  // one classified request as it travels from front to back
  typedef struct packed {
    logic                        is_query;
    logic                        wr_en;     // write lands inside the store
    logic [3:0][OFS_W-1:0]       addr;      // neighbors 00, 10, 01, 11; addr[0] for writes
    logic [VAL_W-1:0]            value;
    logic [FRAC_W-1:0]           fx;
    logic [FRAC_W-1:0]           fy;
  } hbs_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hbs_qstat_t;

endpackage
`default_nettype wire

/* src/hbs_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module hbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* src/hbs_front.sv */
// front pipeline: accepts requests, scales and clamps coordinates, forms grid addresses
`timescale 1ns / 1ps
`default_nettype none
module hbs_front #(
  parameter int GRID_CELLS = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     opcode_i,
  input  wire logic [11:0]              write_index_i,
  input  wire logic signed [23:0]       write_value_i,
  input  wire logic signed [17:0]       query_x_i,
  input  wire logic signed [17:0]       query_y_i,
  input  wire logic [6:0]               w_use_i,
  input  wire logic [6:0]               h_use_i,
  input  wire hbs_pkg::hbs_qstat_t      qstat_i,
  output logic                          push_o,
  output hbs_pkg::hbs_cmd_t             cmd_o
);
  import hbs_pkg::*;

  // scaled coordinate clamped to [0, (size-2) << 16]
  function automatic logic [22:0] clamp_coord(logic signed [24:0] s, logic [SIZE_W-1:0] size);
    logic [22:0] hi;
    hi = {SIZE_W'(size - SIZE_W'(2)), 16'd0};
    if (s[24]) begin
      return '0;
    end else if (s[23:0] > {1'b0, hi}) begin
      return hi;
    end else begin
      return s[22:0];
    end
  endfunction

  logic adv;

  logic                f1_valid_q;
  logic                f1_is_q_q, f1_wr_en_q;
  logic [11:0]         f1_idx_q;
  logic [VAL_W-1:0]    f1_val_q;
  logic signed [24:0]  f1_sx_q, f1_sy_q;
  logic signed [24:0]  sx_d, sy_d;

  logic                f2_valid_q;
  logic                f2_is_q_q, f2_wr_en_q;
  logic [11:0]         f2_idx_q;
  logic [VAL_W-1:0]    f2_val_q;
  logic [22:0]         f2_sx_q, f2_sy_q;

  logic                f3_valid_q;
  hbs_cmd_t            f3_cmd_q, f3_cmd_d;
  logic [OFS_W-1:0]    row_ofs, base;

  assign adv        = !f3_valid_q || !qstat_i.full;
  assign in_ready_o = adv;
  assign push_o     = f3_valid_q && !qstat_i.full;
  assign cmd_o      = f3_cmd_q;

  assign sx_d = query_x_i * $signed({1'b0, w_use_i});
  assign sy_d = query_y_i * $signed({1'b0, h_use_i});

  assign row_ofs = OFS_W'(f2_sy_q[22:16]) * OFS_W'(w_use_i);
  assign base    = row_ofs + OFS_W'(f2_sx_q[22:16]);

  always_comb begin
    f3_cmd_d          = '0;
    f3_cmd_d.is_query = f2_is_q_q;
    f3_cmd_d.wr_en    = f2_wr_en_q;
    f3_cmd_d.value    = f2_val_q;
    f3_cmd_d.fx       = f2_sx_q[15:0];
    f3_cmd_d.fy       = f2_sy_q[15:0];
    if (f2_is_q_q) begin
      f3_cmd_d.addr[0] = base;
      f3_cmd_d.addr[1] = base + OFS_W'(1);
      f3_cmd_d.addr[2] = base + OFS_W'(w_use_i);
      f3_cmd_d.addr[3] = base + OFS_W'(w_use_i) + OFS_W'(1);
    end else begin
      f3_cmd_d.addr[0] = OFS_W'(f2_idx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
      f3_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= in_valid_i;
      f2_valid_q <= f1_valid_q;
      f3_valid_q <= f2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_is_q_q  <= (opcode_i == OP_QUERY);
      f1_wr_en_q <= (32'(write_index_i) < 32'(GRID_CELLS));
      f1_idx_q   <= write_index_i;
      f1_val_q   <= write_value_i;
      f1_sx_q    <= sx_d;
      f1_sy_q    <= sy_d;

      f2_is_q_q  <= f1_is_q_q;
      f2_wr_en_q <= f1_wr_en_q;
      f2_idx_q   <= f1_idx_q;
      f2_val_q   <= f1_val_q;
      f2_sx_q    <= clamp_coord(f1_sx_q, w_use_i);
      f2_sy_q    <= clamp_coord(f1_sy_q, h_use_i);

      f3_cmd_q   <= f3_cmd_d;
    end
  end

endmodule
`default_nettype wire

/* src/hbs_fifo.sv */
// short register queue between front and back pipelines
`timescale 1ns / 1ps
`default_nettype none
module hbs_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire hbs_pkg::hbs_cmd_t  data_i,
  input  wire logic               pop_i,
  output hbs_pkg::hbs_cmd_t       data_o,
  output hbs_pkg::hbs_qstat_t     stat_o
);
  import hbs_pkg::*;

  hbs_cmd_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign stat_o.full  = (count_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

/* src/hbs_back.sv */
// back pipeline: grid store, neighbor fetch, bilinear blend, rounding and output register
`timescale 1ns / 1ps
`default_nettype none
module hbs_back #(
  parameter int GRID_CELLS = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hbs_pkg::hbs_cmd_t  cmd_i,
  input  wire hbs_pkg::hbs_qstat_t qstat_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [22:0]             height_out_o
);
  import hbs_pkg::*;

  localparam int ADDR_W = $clog2(GRID_CELLS);
  localparam int ROW_W  = 42;
  localparam int DIF_W  = 43;
  localparam int SUM_W  = 60;

  logic adv, ram_re, ram_we;
  logic [3:0][VAL_W-1:0] rd_data;

  logic                     b1_valid_q;
  logic [FRAC_W-1:0]        b1_fx_q, b1_fy_q;

  logic                     b2_valid_q;
  logic signed [VAL_W-1:0]  b2_v00_q, b2_v01_q;
  logic signed [VAL_W:0]    b2_dx0_q, b2_dx1_q;
  logic [FRAC_W-1:0]        b2_fx_q, b2_fy_q;

  logic                     b3_valid_q;
  logic signed [ROW_W-1:0]  b3_row0_q, b3_row1_q;
  logic [FRAC_W-1:0]        b3_fy_q;

  logic                     b4_valid_q;
  logic signed [ROW_W-1:0]  b4_row0_q;
  logic signed [DIF_W-1:0]  b4_d_q;
  logic [FRAC_W-1:0]        b4_fy_q;

  logic                     b5_valid_q;
  logic signed [ROW_W-1:0]  b5_row0_q;
  logic [36:0]              b5_pl_q;
  logic signed [38:0]       b5_ph_q;

  logic                     b6_valid_q;
  logic signed [SUM_W-1:0]  b6_sum_q;

  logic                     out_valid_q;
  logic [22:0]              out_data_q, out_data_d;
  logic signed [SUM_W-1:0]  rnd;
  logic [27:0]              rnd_hi;

  assign adv    = !out_valid_q || out_ready_i;
  assign pop_o  = adv && !qstat_i.empty;
  assign ram_re = pop_o && cmd_i.is_query;
  assign ram_we = pop_o && !cmd_i.is_query && cmd_i.wr_en;

  // four copies of the grid, written together, one neighbor read from each
  for (genvar k = 0; k < 4; k++) begin : g_bank
    hbs_ram #(
      .WIDTH(VAL_W),
      .DEPTH(GRID_CELLS)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we),
      .waddr_i(ADDR_W'(cmd_i.addr[0])),
      .wdata_i(cmd_i.value),
      .re_i   (ram_re),
      .raddr_i(ADDR_W'(cmd_i.addr[k])),
      .rdata_o(rd_data[k])
    );
  end

  // sum > 0: round half up at bit 32 and saturate
  assign rnd    = b6_sum_q + $signed({{(SUM_W-32){1'b0}}, 32'h8000_0000});
  assign rnd_hi = rnd[59:32];

  always_comb begin
    if (b6_sum_q[SUM_W-1] || (b6_sum_q == '0)) begin
      out_data_d = '0;
    end else if (|rnd_hi[27:23]) begin
      out_data_d = '1;
    end else begin
      out_data_d = rnd_hi[22:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      b4_valid_q  <= 1'b0;
      b5_valid_q  <= 1'b0;
      b6_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      b1_valid_q  <= ram_re;
      b2_valid_q  <= b1_valid_q;
      b3_valid_q  <= b2_valid_q;
      b4_valid_q  <= b3_valid_q;
      b5_valid_q  <= b4_valid_q;
      b6_valid_q  <= b5_valid_q;
      out_valid_q <= b6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_fx_q   <= cmd_i.fx;
      b1_fy_q   <= cmd_i.fy;

      b2_v00_q  <= $signed(rd_data[0]);
      b2_v01_q  <= $signed(rd_data[2]);
      b2_dx0_q  <= (VAL_W+1)'($signed(rd_data[1])) - (VAL_W+1)'($signed(rd_data[0]));
      b2_dx1_q  <= (VAL_W+1)'($signed(rd_data[3])) - (VAL_W+1)'($signed(rd_data[2]));
      b2_fx_q   <= b1_fx_q;
      b2_fy_q   <= b1_fy_q;

      // horizontal blend in Q.16
      b3_row0_q <= $signed({{2{b2_v00_q[VAL_W-1]}}, b2_v00_q, 16'd0})
                   + b2_dx0_q * $signed({1'b0, b2_fx_q});
      b3_row1_q <= $signed({{2{b2_v01_q[VAL_W-1]}}, b2_v01_q, 16'd0})
                   + b2_dx1_q * $signed({1'b0, b2_fx_q});
      b3_fy_q   <= b2_fy_q;

      b4_row0_q <= b3_row0_q;
      b4_d_q    <= DIF_W'(b3_row1_q) - DIF_W'(b3_row0_q);
      b4_fy_q   <= b3_fy_q;

      // vertical step split into two partial products
      b5_row0_q <= b4_row0_q;
      b5_pl_q   <= b4_d_q[20:0] * b4_fy_q;
      b5_ph_q   <= $signed(b4_d_q[42:21]) * $signed({1'b0, b4_fy_q});

      b6_sum_q  <= (SUM_W'(b5_row0_q) <<< 16) + (SUM_W'(b5_ph_q) <<< 21)
                   + $signed({{(SUM_W-37){1'b0}}, b5_pl_q});

      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign height_out_o = out_data_q;

endmodule
`default_nettype wire

/* src/heightmap_bilinear_sampler.sv */
// Heightmap bilinear sampler: stores a grid of Q16.8 heights and returns one
// bilinearly interpolated, non-negative height per query request. Requests are
// taken one per clock cycle while the queue has room, writes and queries alike,
// and results leave at one per cycle while the sink is ready; after the accepting
// stage, a query passes 2 more front stages, the queue and 7 back stages.
// The rate is set by the grid store: it is kept as four copies that are all
// written by each write request, so the four neighbors of a query are read
// together. A write request produces no result. Grid entries read before they
// are written return arbitrary data; there is no clearing pass after reset. Grid
// size registers may only be changed while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module heightmap_bilinear_sampler #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // write_index[11:0], write_value[35:12], query_x[53:36], query_y[71:54]
  input  wire logic [71:0] s_axis_tdata,
  // opcode[0]
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // height_out[22:0], zero pad[23]
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i
);
  import hbs_pkg::*;

  localparam int GRID_CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [SIZE_W-1:0] W_LIMIT = (MAX_WIDTH > 127) ? 7'd127 : SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] H_LIMIT = (MAX_HEIGHT > 127) ? 7'd127 : SIZE_W'(MAX_HEIGHT);

  logic [SIZE_W-1:0] w_use_q, h_use_q, size_d;
  hbs_cmd_t          front_cmd, head_cmd;
  hbs_qstat_t        qstat;
  logic              push, pop;
  logic [22:0]       height_out;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    size_d = cfg_data_i;
    if (cfg_data_i < SIZE_W'(2)) begin
      size_d = SIZE_W'(2);
    end else if ((cfg_index_i == CFG_GRID_WIDTH) && (cfg_data_i > W_LIMIT)) begin
      size_d = W_LIMIT;
    end else if ((cfg_index_i == CFG_GRID_HEIGHT) && (cfg_data_i > H_LIMIT)) begin
      size_d = H_LIMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_use_q <= (W_LIMIT < 7'd64) ? W_LIMIT : 7'd64;
      h_use_q <= (H_LIMIT < 7'd64) ? H_LIMIT : 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GRID_WIDTH:  w_use_q <= size_d;
        CFG_GRID_HEIGHT: h_use_q <= size_d;
        default: ;
      endcase
    end
  end

  hbs_front #(
    .GRID_CELLS(GRID_CELLS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .opcode_i     (s_axis_tuser[0]),
    .write_index_i(s_axis_tdata[11:0]),
    .write_value_i($signed(s_axis_tdata[35:12])),
    .query_x_i    ($signed(s_axis_tdata[53:36])),
    .query_y_i    ($signed(s_axis_tdata[71:54])),
    .w_use_i      (w_use_q),
    .h_use_i      (h_use_q),
    .qstat_i      (qstat),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  hbs_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(front_cmd),
    .pop_i (pop),
    .data_o(head_cmd),
    .stat_o(qstat)
  );

  hbs_back #(
    .GRID_CELLS(GRID_CELLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .height_out_o(height_out)
  );

  assign m_axis_tdata = {1'b0, height_out};

`ifndef SYNTHESIS
  // the front only holds off requests when the queue is full
  a_front_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> qstat.full)
    else $error("front stalled while queue has room");

  // the back never takes from the queue while a result is blocked
  a_back_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!m_axis_tvalid || m_axis_tready))
    else $error("queue popped while output is stalled");

  // grid sizes in use stay within the supported range
  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w_use_q >= SIZE_W'(2)) && (w_use_q <= W_LIMIT)
    && (h_use_q >= SIZE_W'(2)) && (h_use_q <= H_LIMIT))
    else $error("grid size register out of range");
`endif

endmodule
`default_nettype wire

/* tb/tb_heightmap_bilinear_sampler.sv */
// self-checking testbench for the heightmap bilinear sampler: grid writes, queries, size settings
`timescale 1ns / 1ps
module tb_heightmap_bilinear_sampler;
  import hbs_pkg::*;

  localparam int GRID_MAX_W     = 64;
  localparam int GRID_MAX_H     = 64;
  localparam int GRID_CELLS     = GRID_MAX_W * GRID_MAX_H;
  localparam int DRAIN_SLACK    = 30;    // slack exceeds the pipeline depth, writes leave nothing behind
  localparam int WATCHDOG_LIMIT = 2000;  // longest silent stretch is the sink hold of the backpressure test

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // write_index[11:0], write_value[35:12], query_x[53:36], query_y[71:54]
  logic [71:0] s_axis_tdata = '0;
  // opcode[0]
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // height_out[22:0], zero pad[23]
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [6:0]  cfg_data_i = '0;

  // shadow of the block state
  logic signed [VAL_W-1:0] grid_model [GRID_CELLS];
  bit                      grid_written [GRID_CELLS];
  logic [SIZE_W-1:0]       grid_width_reg = 7'd64;
  logic [SIZE_W-1:0]       grid_height_reg = 7'd64;
  logic [22:0]             expected_heights [$];

  int error_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int sink_hold_cycles = 0;
  int silent_cycles = 0;

  heightmap_bilinear_sampler #(
    .MAX_WIDTH (GRID_MAX_W),
    .MAX_HEIGHT(GRID_MAX_H)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int size_in_use(logic [SIZE_W-1:0] size_reg, int max_size);
    if (size_reg < 2) return 2;
    if (size_reg > max_size) return max_size;
    return int'(size_reg);
  endfunction

  function automatic longint scale_clamp(logic signed [17:0] coord, int size);
    longint scaled;
    longint upper;
    scaled = longint'(coord) * size;
    upper  = longint'(size - 2) * 65536;
    if (scaled < 0) scaled = 0;
    if (scaled > upper) scaled = upper;
    return scaled;
  endfunction

  function automatic logic [22:0] predict_height(logic signed [17:0] qx, logic signed [17:0] qy);
    int     w, h, ix, iy, row0, row1;
    longint sx, sy, fx, fy, sum, rounded;
    w    = size_in_use(grid_width_reg, GRID_MAX_W);
    h    = size_in_use(grid_height_reg, GRID_MAX_H);
    sx   = scale_clamp(qx, w);
    sy   = scale_clamp(qy, h);
    ix   = int'(sx / 65536);
    iy   = int'(sy / 65536);
    fx   = sx % 65536;
    fy   = sy % 65536;
    row0 = iy * w;
    row1 = (iy + 1) * w;
    sum  = longint'(grid_model[row0 + ix])     * ((65536 - fx) * (65536 - fy))
         + longint'(grid_model[row0 + ix + 1]) * (fx * (65536 - fy))
         + longint'(grid_model[row1 + ix])     * ((65536 - fx) * fy)
         + longint'(grid_model[row1 + ix + 1]) * (fx * fy);
    if (sum <= 0) return '0;
    // round to nearest, halves up
    rounded = (sum + (longint'(1) <<< 31)) >>> 32;
    if (rounded > 64'h7FFFFF) rounded = 64'h7FFFFF;
    return rounded[22:0];
  endfunction

  task automatic report_mismatch(string what, logic [22:0] want, logic [22:0] got);
    $display("%0t mismatch: %s expected %0d got %0d", $realtime, what, want, got);
    error_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_heights.size() == 0) begin
        report_mismatch("height_out with no query pending", '0, m_axis_tdata[22:0]);
      end else if (m_axis_tdata[22:0] !== expected_heights[0]) begin
        report_mismatch("height_out", expected_heights[0], m_axis_tdata[22:0]);
        void'(expected_heights.pop_front());
      end else begin
        void'(expected_heights.pop_front());
      end
    end
  end

  // result sink: random stalls plus an optional long hold
  always @(negedge clk_i) begin
    if (sink_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      silent_cycles = 0;
    end else begin
      silent_cycles++;
    end
    if (silent_cycles >= WATCHDOG_LIMIT) begin
      $display("heightmap_bilinear_sampler regression: fail");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_request(hbs_op_e op, logic [11:0] index, logic [VAL_W-1:0] value,
                              logic [17:0] qx, logic [17:0] qy);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {qy, qx, value, index};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_WRITE) begin
      grid_model[index]   = value;
      grid_written[index] = 1'b1;
    end else begin
      expected_heights.push_back(predict_height(qx, qy));
    end
    @(negedge clk_i);
  endtask

  // the unused fields carry random bits
  task automatic send_write(int index, logic [VAL_W-1:0] value);
    send_request(OP_WRITE, index[11:0], value, 18'($urandom), 18'($urandom));
  endtask

  task automatic send_query(logic [17:0] qx, logic [17:0] qy);
    send_request(OP_QUERY, 12'($urandom), 24'($urandom), qx, qy);
  endtask

  function automatic logic [VAL_W-1:0] random_height();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 24'($urandom_range(0, 1 << 20));
    if (pick < 85) return 24'($urandom);
    return 24'(int'($urandom_range(0, 1023)) - 512);
  endfunction

  function automatic logic [17:0] random_coord();
    int pick;
    logic [17:0] edges [8];
    edges = '{18'h20000, 18'h3FFFF, 18'h00000, 18'h00001,
              18'h0FFFF, 18'h10000, 18'h1FFFF, 18'h08000};
    pick = $urandom_range(99);
    if (pick < 50) return 18'($urandom_range(0, 65535));
    if (pick < 75) return 18'($urandom);
    return edges[$urandom_range(0, 7)];
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_heights.size() != 0) @(negedge clk_i);
    repeat (DRAIN_SLACK) @(negedge clk_i);
  endtask

  task automatic write_register(hbs_cfg_e index, logic [SIZE_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == CFG_GRID_WIDTH) grid_width_reg = value;
    else grid_height_reg = value;
    @(negedge clk_i);
  endtask

  task automatic set_grid(logic [SIZE_W-1:0] width_reg, logic [SIZE_W-1:0] height_reg);
    write_register(CFG_GRID_WIDTH, width_reg);
    write_register(CFG_GRID_HEIGHT, height_reg);
    cfg_valid_i <= 1'b0;
  endtask

  // every cell a query can touch must hold a written height
  task automatic fill_grid_in_use();
    int cells;
    cells = size_in_use(grid_width_reg, GRID_MAX_W) * size_in_use(grid_height_reg, GRID_MAX_H);
    for (int i = 0; i < cells; i++) begin
      if (!grid_written[i]) send_write(i, random_height());
    end
  endtask

  task automatic test_directed();
    set_grid(7'd3, 7'd3);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_write(0, 24'h7FFFFF);
    send_write(1, 24'h800000);
    send_write(2, 24'd500);
    send_write(3, -24'sd1000);
    send_write(4, 24'd2560);
    send_write(5, 24'd257);
    send_write(6, 24'd0);
    send_write(7, 24'h800000);
    send_write(8, 24'h7FFFFF);
    send_write(4095, 24'h800000);         // stored outside the grid in use
    send_query(18'd0, 18'd0);
    send_query(18'h20000, 18'h20000);     // most negative, clamped to the first cell
    send_query(18'h1FFFF, 18'h1FFFF);     // most positive, clamped to the last cell pair
    send_query(18'd32768, 18'd0);         // negative mix gives zero
    send_query(18'd10923, 18'd0);         // near balance of both extremes
    send_query(18'd0, 18'd32768);
    send_query(18'd21845, 18'd21845);     // fractions just under one
    send_query(18'd65535, 18'd65535);
    send_query(18'd1, 18'd1);
    send_query(18'h3FFFF, 18'd43690);
    send_query(18'd30000, 18'd15000);
    send_query(18'd32768, 18'h1FFFF);     // exact half, rounds up
  endtask

  task automatic run_random_phase(logic [SIZE_W-1:0] width_reg, logic [SIZE_W-1:0] height_reg,
                                  int count, int src_pct, int sink_pct);
    int cells;
    wait_drained();
    set_grid(width_reg, height_reg);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    fill_grid_in_use();
    cells = size_in_use(grid_width_reg, GRID_MAX_W) * size_in_use(grid_height_reg, GRID_MAX_H);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 25) begin
        if ($urandom_range(99) < 70) send_write($urandom_range(0, cells - 1), random_height());
        else send_write($urandom_range(0, GRID_CELLS - 1), random_height());
      end else begin
        send_query(random_coord(), random_coord());
      end
    end
  endtask

  // sink holds off while queries keep coming, so the request side must stall
  task automatic test_input_backpressure();
    wait_drained();
    set_grid(7'd8, 7'd8);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    fill_grid_in_use();
    wait_drained();
    @(posedge clk_i);
    sink_hold_cycles = 400;
    @(negedge clk_i);
    repeat (60) send_query(random_coord(), random_coord());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    run_random_phase(7'd64, 7'd4, 150, 0, 0);
    run_random_phase(7'd0, 7'd1, 100, 66, 0);     // below range, used as 2x2
    run_random_phase(7'd127, 7'd2, 150, 0, 66);   // width above range, used as 64
    run_random_phase(7'd2, 7'd127, 150, 34, 34);  // height above range, used as 64
    run_random_phase(7'd64, 7'd2, 100, 66, 0);
    run_random_phase(7'($urandom_range(2, 16)), 7'($urandom_range(2, 16)), 150, 34, 34);
    run_random_phase(7'd5, 7'd17, 100, 0, 66);
    test_input_backpressure();
    wait_drained();
    if (error_count == 0) begin
      $display("heightmap_bilinear_sampler regression: pass");
    end else begin
      $display("heightmap_bilinear_sampler regression: fail");
    end
    $finish;
  end

endmodule
